FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL. Each check is sampled on the rising
// clock edge and is switched off while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property that holds in the same cycle.
`define QMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle leads to another in the next cycle.
`define QMM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/core/qmm_pkg.sv
package qmm_pkg;

  localparam int NMOT      = 4;
  localparam int WIDTH_W   = 16;
  localparam int CORR_W    = 16;
  localparam int PCT_W     = 7;
  localparam int PCT_N     = 1 << PCT_W;
  // 127 * 65535 / 100 fits in 17 bits.
  localparam int THR_W     = 17;
  // Widest mix sum is 65535 + 83229 + 3 * 32768; lowest is -3 * 32768.
  localparam int SUM_W     = 19;
  localparam int REG_IDX_W = 3;
  localparam int MOT_IDX_W = 2;

  localparam int IN_TDATA_W  = 56;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 72;

  localparam int KILL_WIDTH_DEF    = 2000;
  localparam int THROTTLE_SPAN_DEF = 2000;

  localparam logic [WIDTH_W-1:0] MIN_RESET = WIDTH_W'(2200);
  localparam logic [WIDTH_W-1:0] MAX_RESET = WIDTH_W'(4000);

  // Motor order: front-left, front-right, back-right, back-left.
  // A set bit means the correction is subtracted for that motor.
  localparam logic [NMOT-1:0] ROLL_NEG  = 4'b0110;
  localparam logic [NMOT-1:0] PITCH_NEG = 4'b0011;
  localparam logic [NMOT-1:0] YAW_NEG   = 4'b0101;

  typedef enum logic [1:0] {
    FUNC_MIX  = 2'd0,
    FUNC_RAMP = 2'd1,
    FUNC_KILL = 2'd2,
    FUNC_IDLE = 2'd3
  } func_t;

  typedef struct packed {
    func_t                     func;
    logic [THR_W-1:0]          thr;
    logic signed [CORR_W-1:0]  roll;
    logic signed [CORR_W-1:0]  pitch;
    logic signed [CORR_W-1:0]  yaw;
  } mix_cmd_t;

  typedef logic [THR_W-1:0] thr_tab_t [PCT_N];

  // Scaled throttle for every percent code, built at elaboration.
  function automatic thr_tab_t thr_table(input int unsigned span);
    thr_tab_t tab;
    for (int i = 0; i < PCT_N; i++) begin
      tab[i] = THR_W'((i * span) / 100);
    end
    return tab;
  endfunction

endpackage

FILE: rtl/core/qmm_lane.sv
module qmm_lane #(
  parameter int MOTOR      = 0,
  parameter int KILL_WIDTH = qmm_pkg::KILL_WIDTH_DEF
) (
  input  qmm_pkg::mix_cmd_t              cmd,
  input  logic [qmm_pkg::WIDTH_W-1:0]    min_width,
  input  logic [qmm_pkg::WIDTH_W-1:0]    max_width,
  input  logic [qmm_pkg::WIDTH_W-1:0]    width_cur,
  output logic [qmm_pkg::WIDTH_W-1:0]    width_nxt,
  output logic                           at_min
);
  import qmm_pkg::*;

  logic signed [SUM_W-1:0] mn_s;
  logic signed [SUM_W-1:0] mx_s;
  logic signed [SUM_W-1:0] thr_s;
  logic signed [SUM_W-1:0] roll_s;
  logic signed [SUM_W-1:0] pitch_s;
  logic signed [SUM_W-1:0] yaw_s;
  logic signed [SUM_W-1:0] sum;
  logic [WIDTH_W-1:0]      mix_width;

  always_comb begin
    mn_s    = signed'(SUM_W'(min_width));
    mx_s    = signed'(SUM_W'(max_width));
    thr_s   = signed'(SUM_W'(cmd.thr));
    roll_s  = ROLL_NEG[MOTOR]  ? -SUM_W'(cmd.roll)  : SUM_W'(cmd.roll);
    pitch_s = PITCH_NEG[MOTOR] ? -SUM_W'(cmd.pitch) : SUM_W'(cmd.pitch);
    yaw_s   = YAW_NEG[MOTOR]   ? -SUM_W'(cmd.yaw)   : SUM_W'(cmd.yaw);
    sum     = mn_s + thr_s + roll_s + pitch_s + yaw_s;

    // When the limits are crossed, the maximum wins for a sum above it, else the minimum.
    if (sum > mx_s) begin
      mix_width = max_width;
    end else if (sum < mn_s) begin
      mix_width = min_width;
    end else begin
      mix_width = sum[WIDTH_W-1:0];
    end
  end

  always_comb begin
    case (cmd.func)
      FUNC_MIX:  width_nxt = mix_width;
      FUNC_RAMP: width_nxt = (width_cur < min_width) ? width_cur + 1'b1 : width_cur;
      FUNC_KILL: width_nxt = WIDTH_W'(KILL_WIDTH);
      FUNC_IDLE: width_nxt = min_width;
      default:   width_nxt = width_cur;
    endcase
    at_min = (width_nxt >= min_width);
  end

endmodule

FILE: rtl/core/quad_motor_mixer_with_ramp.sv
// Four-motor X-frame mixer with a start-up ramp. Every input item gives
// exactly one result item with the four pulse widths and the motors_on flag
// as they stand after the item. An item passes through an input register and
// is mixed into the result register, which also updates the stored widths,
// so a new item is taken every clock cycle while the output is not stalled.
// Its result is registered in the result register and held there until
// out_tready takes it. The user must write the minimum and maximum width
// registers through the cfg port only while no item is in flight; the
// block itself does not enforce this.
module quad_motor_mixer_with_ramp #(
  parameter int KILL_WIDTH    = qmm_pkg::KILL_WIDTH_DEF,
  parameter int THROTTLE_SPAN = qmm_pkg::THROTTLE_SPAN_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [qmm_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [qmm_pkg::WIDTH_W-1:0]        cfg_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // throttle_pct, roll_corr, pitch_corr, yaw_corr
  input  logic [qmm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // func
  input  logic [qmm_pkg::IN_TUSER_W-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // width_front_left, width_front_right, width_back_right, width_back_left,
  // motors_on
  output logic [qmm_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import qmm_pkg::*;

  `include "assert_macros.svh"

  localparam thr_tab_t ThrTable = thr_table(THROTTLE_SPAN);

  logic [WIDTH_W-1:0]     min_r [NMOT];
  logic [WIDTH_W-1:0]     max_r [NMOT];
  logic [WIDTH_W-1:0]     width_r [NMOT];
  logic [WIDTH_W-1:0]     width_nxt [NMOT];
  logic [NMOT-1:0]        at_min;
  logic                   running_r;
  logic                   running_nxt;

  logic                   in_valid_r;
  logic [IN_TDATA_W-1:0]  in_tdata_r;
  logic [IN_TUSER_W-1:0]  in_tuser_r;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   advance;
  mix_cmd_t               cmd;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_tdata_r <= in_tdata;
      in_tuser_r <= in_tuser;
    end
  end

  always_comb begin
    cmd.func  = func_t'(in_tuser_r);
    cmd.thr   = ThrTable[in_tdata_r[6:0]];
    cmd.roll  = signed'(in_tdata_r[22:7]);
    cmd.pitch = signed'(in_tdata_r[38:23]);
    cmd.yaw   = signed'(in_tdata_r[54:39]);
  end

  // Index bit 2 picks the maximum bank, the low bits pick the motor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NMOT; i++) begin
        min_r[i] <= MIN_RESET;
        max_r[i] <= MAX_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index[REG_IDX_W-1]) begin
        max_r[cfg_index[MOT_IDX_W-1:0]] <= cfg_data;
      end else begin
        min_r[cfg_index[MOT_IDX_W-1:0]] <= cfg_data;
      end
    end
  end

  for (genvar m = 0; m < NMOT; m++) begin : g_lane
    qmm_lane #(
      .MOTOR      (m),
      .KILL_WIDTH (KILL_WIDTH)
    ) u_lane (
      .cmd       (cmd),
      .min_width (min_r[m]),
      .max_width (max_r[m]),
      .width_cur (width_r[m]),
      .width_nxt (width_nxt[m]),
      .at_min    (at_min[m])
    );
  end

  always_comb begin
    case (cmd.func)
      FUNC_RAMP: running_nxt = running_r || (&at_min);
      FUNC_KILL: running_nxt = 1'b0;
      default:   running_nxt = running_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NMOT; i++) begin
        width_r[i] <= WIDTH_W'(KILL_WIDTH);
      end
      running_r <= 1'b0;
    end else if (advance) begin
      for (int i = 0; i < NMOT; i++) begin
        width_r[i] <= width_nxt[i];
      end
      running_r <= running_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_tdata_r <= {7'b0, running_nxt, width_nxt[3], width_nxt[2],
                      width_nxt[1], width_nxt[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  `QMM_ASSERT_NEXT(a_kill_clears, advance && (cmd.func == FUNC_KILL), !running_r, "kill left motors_on set")
  `QMM_ASSERT_NEXT(a_idle_min, advance && (cmd.func == FUNC_IDLE), width_r[0] == $past(min_r[0]), "idle width differs from minimum")
  `QMM_ASSERT(a_run_rise, $rose(running_r) |-> $past(advance && (cmd.func == FUNC_RAMP)), "motors_on set without a ramp item")
  `QMM_ASSERT_NEXT(a_mix_floor, advance && (cmd.func == FUNC_MIX) && (min_r[1] <= max_r[1]), (width_r[1] >= $past(min_r[1])) && (width_r[1] <= $past(max_r[1])), "mixed width outside its limits")
  `QMM_ASSERT_NEXT(a_result_match, advance, out_valid_r && (out_tdata_r[15:0] == width_r[0]) && (out_tdata_r[64] == running_r), "result does not match stored state")

endmodule
